@@ design/thc_pkg.sv @@
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants for the tilt-compensated heading
// Widths, pipeline stage structures, register indexes and the arctangent
// table used by both rows of CORDIC cells.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int AW     = 32;  // scaled axis value
    localparam int XW     = 33;  // rotation-mode vector component
    localparam int ANW    = 26;  // angle in Q.16 degrees
    localparam int VW     = 64;  // vectoring-mode vector component
    localparam int TAB_LEN = 24;

    localparam logic signed [27:0] DEG90  = 28'sd5898240;
    localparam logic signed [27:0] DEG180 = 28'sd11796480;
    localparam logic signed [XW-1:0] K_Q30 = 33'sd652032874;

    typedef enum logic [2:0] {
        REG_GAIN_X   = 3'd0,
        REG_GAIN_Y   = 3'd1,
        REG_GAIN_Z   = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5
    } cfg_idx_t;

    // Sine/cosine stage: roll and pitch rotations side by side, plus the
    // scaled axes that travel with them.
    typedef struct packed {
        logic                  vld;
        logic signed [XW-1:0]  rx;
        logic signed [XW-1:0]  ry;
        logic signed [ANW-1:0] ra;
        logic                  rflip;
        logic signed [XW-1:0]  px;
        logic signed [XW-1:0]  py;
        logic signed [ANW-1:0] pa;
        logic                  pflip;
        logic signed [AW-1:0]  ax;
        logic signed [AW-1:0]  ay;
        logic signed [AW-1:0]  az;
    } sc_t;

    // Arctangent stage.
    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic signed [VW-1:0]  x;
        logic signed [VW-1:0]  y;
        logic signed [ANW-1:0] z;
    } vec_t;

    // atan(2^-i) in Q.16 degrees, rounded to nearest.
    function automatic logic signed [ANW-1:0] atan_val(input int unsigned i);
        case (i)
            0:  return 26'sd2949120;
            1:  return 26'sd1740967;
            2:  return 26'sd919879;
            3:  return 26'sd466945;
            4:  return 26'sd234379;
            5:  return 26'sd117304;
            6:  return 26'sd58666;
            7:  return 26'sd29335;
            8:  return 26'sd14668;
            9:  return 26'sd7334;
            10: return 26'sd3667;
            11: return 26'sd1833;
            12: return 26'sd917;
            13: return 26'sd458;
            14: return 26'sd229;
            15: return 26'sd115;
            16: return 26'sd57;
            17: return 26'sd29;
            18: return 26'sd14;
            19: return 26'sd7;
            20: return 26'sd4;
            21: return 26'sd2;
            22: return 26'sd1;
            default: return 26'sd0;
        endcase
    endfunction

endpackage

@@ design/thc_rot_cell.sv @@
// ----------------------------------------------------------------------------
// thc_rot_cell: one rotation-mode CORDIC cell
// Advances the roll and pitch sine/cosine rotations by one micro-rotation.
// ----------------------------------------------------------------------------
module thc_rot_cell
    import thc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  sc_t  d,
    output sc_t  q
);

    localparam logic signed [ANW-1:0] T = atan_val(STAGE);

    sc_t q_next;

    always_comb
    begin
        q_next = d;
        if (d.ra >= 0)
        begin
            q_next.rx = d.rx - (d.ry >>> STAGE);
            q_next.ry = d.ry + (d.rx >>> STAGE);
            q_next.ra = d.ra - T;
        end
        else
        begin
            q_next.rx = d.rx + (d.ry >>> STAGE);
            q_next.ry = d.ry - (d.rx >>> STAGE);
            q_next.ra = d.ra + T;
        end
        if (d.pa >= 0)
        begin
            q_next.px = d.px - (d.py >>> STAGE);
            q_next.py = d.py + (d.px >>> STAGE);
            q_next.pa = d.pa - T;
        end
        else
        begin
            q_next.px = d.px + (d.py >>> STAGE);
            q_next.py = d.py - (d.px >>> STAGE);
            q_next.pa = d.pa + T;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q.vld <= 1'b0;
        end
        else if (en)
        begin
            q <= q_next;
        end
    end

endmodule

@@ design/thc_vec_cell.sv @@
// ----------------------------------------------------------------------------
// thc_vec_cell: one vectoring-mode CORDIC cell
// Drives the vector towards the X axis and accumulates the angle.
// ----------------------------------------------------------------------------
module thc_vec_cell
    import thc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  vec_t d,
    output vec_t q
);

    localparam logic signed [ANW-1:0] T = atan_val(STAGE);

    vec_t q_next;

    always_comb
    begin
        q_next = d;
        if (d.y >= 0)
        begin
            q_next.x = d.x + (d.y >>> STAGE);
            q_next.y = d.y - (d.x >>> STAGE);
            q_next.z = d.z + T;
        end
        else
        begin
            q_next.x = d.x - (d.y >>> STAGE);
            q_next.y = d.y + (d.x >>> STAGE);
            q_next.z = d.z - T;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q.vld <= 1'b0;
        end
        else if (en)
        begin
            q <= q_next;
        end
    end

endmodule

@@ design/tilt_compensated_heading.sv @@
// ----------------------------------------------------------------------------
// tilt_compensated_heading: e-compass heading with tilt compensation
// Scales a magnetometer sample, rotates it into the horizontal plane using
// CORDIC sine/cosine of roll and pitch, and returns minus atan2 in degrees.
// ----------------------------------------------------------------------------
// Usage.
// One transfer on the s_ channel carries a raw three-axis field sample with
// the current roll and pitch angles; exactly one transfer on the m_ channel
// later carries the heading, in Q9.8 degrees, in the same order.
// The cfg_ channel writes the gain and hard-iron offset registers; it is
// always ready and should only be used while no sample is in flight.
// The datapath is a single pipeline: one input stage, a row of N rotation
// cells, a rounding stage, four multiply and sum stages, a fold stage, a
// row of N vectoring cells and the output register, where N is
// CORDIC_STAGES capped at 24. A new sample is taken in every cycle while
// the pipeline is not halted by a stalled receiver.
// The whole pipeline advances together. When the receiver stalls with a
// result waiting, the pipeline still moves while its last stage is empty,
// so bubbles are squeezed out; it halts only when a finished result would
// otherwise be overwritten.
// Reset clears every valid flag and loads the registers with their
// calibration defaults; payload registers are left as they are.
// ----------------------------------------------------------------------------
module tilt_compensated_heading
    import thc_pkg::*;
#(
    parameter int CORDIC_STAGES  = 16,
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // field_x[12:0], field_y[25:13], field_z[38:26], roll_angle[55:39],
    // pitch_angle[72:56], zero padding above
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // heading[16:0], zero padding above
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int N = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    // Configuration registers.
    logic signed [15:0] gain_x_reg, gain_y_reg, gain_z_reg;
    logic signed [11:0] offset_x_reg, offset_y_reg, offset_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x_reg   <= 16'sd4096;
            gain_y_reg   <= 16'sd4096;
            gain_z_reg   <= 16'sd4096;
            offset_x_reg <= 12'sd12;
            offset_y_reg <= -12'sd79;
            offset_z_reg <= -12'sd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GAIN_X:   gain_x_reg   <= cfg_data;
                REG_GAIN_Y:   gain_y_reg   <= cfg_data;
                REG_GAIN_Z:   gain_z_reg   <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data[11:0];
                REG_OFFSET_Y: offset_y_reg <= cfg_data[11:0];
                REG_OFFSET_Z: offset_z_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance. The output register loads whenever it is free or
    // being emptied; the rest of the pipeline also moves when the item in
    // its last stage is only a bubble.
    sc_t  sc  [0:N];
    vec_t vec [0:N];
    logic out_load;
    logic en;
    logic out_vld_reg;
    logic signed [16:0] heading_reg;

    assign out_load = !out_vld_reg || m_tready;
    assign en       = out_load || !vec[N].vld;
    assign s_tready = en;

    // Input stage: scale the axes and fold the angles into +-90 degrees.
    logic signed [12:0] fx, fy, fz;
    logic signed [16:0] roll, pitch;
    logic signed [28:0] prod_x, prod_y, prod_z;
    logic signed [27:0] roll_e, pitch_e;
    sc_t sc0_next;

    assign fx    = s_tdata[12:0];
    assign fy    = s_tdata[25:13];
    assign fz    = s_tdata[38:26];
    assign roll  = s_tdata[55:39];
    assign pitch = s_tdata[72:56];

    assign prod_x = fx * gain_x_reg;
    assign prod_y = fy * gain_y_reg;
    assign prod_z = fz * gain_z_reg;

    assign roll_e  = 28'($signed({roll, 8'b0}));
    assign pitch_e = 28'($signed({pitch, 8'b0}));

    always_comb
    begin
        sc0_next       = '0;
        sc0_next.vld   = s_tvalid;
        sc0_next.ax    = -AW'(prod_x) - (AW'(offset_x_reg) <<< GAIN_FRAC_BITS);
        sc0_next.ay    =  AW'(prod_y) - (AW'(offset_y_reg) <<< GAIN_FRAC_BITS);
        sc0_next.az    = -AW'(prod_z) - (AW'(offset_z_reg) <<< GAIN_FRAC_BITS);
        sc0_next.rx    = K_Q30;
        sc0_next.px    = K_Q30;
        sc0_next.ry    = '0;
        sc0_next.py    = '0;
        // Angles beyond a right angle fold back; the cosine is negated later.
        if (roll_e > DEG90)
        begin
            sc0_next.ra    = ANW'(DEG180 - roll_e);
            sc0_next.rflip = 1'b1;
        end
        else if (roll_e < -DEG90)
        begin
            sc0_next.ra    = ANW'(-DEG180 - roll_e);
            sc0_next.rflip = 1'b1;
        end
        else
        begin
            sc0_next.ra    = ANW'(roll_e);
            sc0_next.rflip = 1'b0;
        end
        if (pitch_e > DEG90)
        begin
            sc0_next.pa    = ANW'(DEG180 - pitch_e);
            sc0_next.pflip = 1'b1;
        end
        else if (pitch_e < -DEG90)
        begin
            sc0_next.pa    = ANW'(-DEG180 - pitch_e);
            sc0_next.pflip = 1'b1;
        end
        else
        begin
            sc0_next.pa    = ANW'(pitch_e);
            sc0_next.pflip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc[0].vld <= 1'b0;
        end
        else if (en)
        begin
            sc[0] <= sc0_next;
        end
    end

    // Row of rotation cells producing sine and cosine of both angles.
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        thc_rot_cell #(.STAGE(i)) u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (sc[i]),
            .q     (sc[i + 1])
        );
    end

    // Round to Q2.14 with saturation.
    function automatic logic signed [15:0] rnd_sat(input logic signed [XW-1:0] v);
        logic signed [XW:0] r;
        r = ((XW + 1)'(v) + (XW + 1)'(32768)) >>> 16;
        if (r > 16384)
            return 16'sd16384;
        else if (r < -16384)
            return -16'sd16384;
        else
            return 16'(r);
    endfunction

    logic               trig_vld_reg;
    logic signed [15:0] sr_reg, cr_reg, sp_reg, cp_reg;
    logic signed [AW-1:0] tax_reg, tay_reg, taz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            trig_vld_reg <= sc[N].vld;
            sr_reg       <= rnd_sat(sc[N].ry);
            sp_reg       <= rnd_sat(sc[N].py);
            cr_reg       <= sc[N].rflip ? -rnd_sat(sc[N].rx) : rnd_sat(sc[N].rx);
            cp_reg       <= sc[N].pflip ? -rnd_sat(sc[N].px) : rnd_sat(sc[N].px);
            tax_reg      <= sc[N].ax;
            tay_reg      <= sc[N].ay;
            taz_reg      <= sc[N].az;
        end
    end

    // Products of axes with sines and cosines.
    logic               p1_vld_reg;
    logic signed [47:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [15:0] sp1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= trig_vld_reg;
            m1_reg     <= taz_reg * sr_reg;
            m2_reg     <= tay_reg * cr_reg;
            m3_reg     <= tay_reg * sr_reg;
            m4_reg     <= taz_reg * cr_reg;
            m5_reg     <= tax_reg * cp_reg;
            sp1_reg    <= sp_reg;
        end
    end

    // Sums of products.
    logic               p2_vld_reg;
    logic signed [48:0] d_reg, u_reg;
    logic signed [47:0] m5b_reg;
    logic signed [15:0] sp2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_vld_reg <= p1_vld_reg;
            d_reg      <= 49'(m1_reg) - 49'(m2_reg);
            u_reg      <= 49'(m3_reg) + 49'(m4_reg);
            m5b_reg    <= m5_reg;
            sp2_reg    <= sp1_reg;
        end
    end

    // The wide sum times the pitch sine, in two partial products.
    logic               p3_vld_reg;
    logic signed [VW-1:0] bfy3_reg;
    logic signed [40:0] plo_reg, phi_reg;
    logic signed [47:0] m5c_reg;
    logic signed [24:0] u_lo, u_hi;

    assign u_lo = $signed({1'b0, u_reg[23:0]});
    assign u_hi = u_reg[48:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_vld_reg <= p2_vld_reg;
            bfy3_reg   <= VW'(d_reg) <<< 14;
            plo_reg    <= u_lo * sp2_reg;
            phi_reg    <= u_hi * sp2_reg;
            m5c_reg    <= m5b_reg;
        end
    end

    // Horizontal field components.
    logic               p4_vld_reg;
    logic signed [VW-1:0] bfx_reg, bfy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_vld_reg <= p3_vld_reg;
            bfx_reg    <= (VW'(m5c_reg) <<< 14) + (VW'(phi_reg) <<< 24) + VW'(plo_reg);
            bfy_reg    <= bfy3_reg;
        end
    end

    // Start of atan2(-bfy, bfx): vectors in the left half-plane are turned
    // by a right angle first.
    vec_t vec0_next;
    logic signed [VW-1:0] yv;

    assign yv = -bfy_reg;

    always_comb
    begin
        vec0_next      = '0;
        vec0_next.vld  = p4_vld_reg;
        vec0_next.zero = (bfx_reg == '0) && (bfy_reg == '0);
        if (bfx_reg < 0)
        begin
            if (yv >= 0)
            begin
                vec0_next.x = yv;
                vec0_next.y = -bfx_reg;
                vec0_next.z = ANW'(DEG90);
            end
            else
            begin
                vec0_next.x = -yv;
                vec0_next.y = bfx_reg;
                vec0_next.z = -ANW'(DEG90);
            end
        end
        else
        begin
            vec0_next.x = bfx_reg;
            vec0_next.y = yv;
            vec0_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec[0].vld <= 1'b0;
        end
        else if (en)
        begin
            vec[0] <= vec0_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        thc_vec_cell #(.STAGE(i)) u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (vec[i]),
            .q     (vec[i + 1])
        );
    end

    // Heading: minus the angle, rounded to Q9.8 and saturated.
    logic signed [ANW:0]   neg_z;
    logic signed [ANW-8:0] h_raw;
    logic signed [16:0]    heading_next;

    assign neg_z = -(ANW + 1)'(vec[N].z) + (ANW + 1)'(128);
    assign h_raw = (ANW - 7)'(neg_z >>> 8);

    always_comb
    begin
        if (vec[N].zero)
            heading_next = '0;
        else if (h_raw > 46080)
            heading_next = 17'sd46080;
        else if (h_raw < -46080)
            heading_next = -17'sd46080;
        else
            heading_next = 17'(h_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= vec[N].vld;
            heading_reg <= heading_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, heading_reg};

endmodule

@@ design/thc_checker.sv @@
// ----------------------------------------------------------------------------
// thc_checker: port-level checks for the heading block
// Watches the result channel and its payload; bound to the top level.
// ----------------------------------------------------------------------------
module thc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[16:0]) <= 46080) &&
                     ($signed(m_tdata[16:0]) >= -46080))
        else $error("heading out of range");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:17] == 7'b0))
        else $error("padding bits set");

endmodule

bind tilt_compensated_heading thc_checker u_thc_checker (.*);
